// ===== sv/rsps_pkg.sv =====
// ----------------------------------------------------------------------------
// rsps_pkg
// Shared types and constants for the radio serial packet shifter.
// ----------------------------------------------------------------------------
package rsps_pkg;

    // Field widths fixed by the interface.
    localparam int RSPS_SHIFT_W        = 16;
    localparam int RSPS_CNT_W          = 5;
    localparam int RSPS_ADDR_LEN_W     = 3;
    localparam int RSPS_DEST_W         = 40;
    localparam int RSPS_CHAN_W         = 8;
    localparam int RSPS_CFG_IDX_W      = 2;
    localparam int RSPS_MAX_ADDR_BYTES = 5;

    localparam logic [RSPS_CHAN_W-1:0] RSPS_CHAN_RESET = 8'h64;

    // Configuration register indexes.
    localparam logic [RSPS_CFG_IDX_W-1:0] CFG_ADDR_LEN  = 2'd0;
    localparam logic [RSPS_CFG_IDX_W-1:0] CFG_DEST_ADDR = 2'd1;
    localparam logic [RSPS_CFG_IDX_W-1:0] CFG_CHANNEL   = 2'd2;

    // Request commands.
    typedef enum logic [1:0] {
        CMD_SEND    = 2'd0,
        CMD_RECEIVE = 2'd1,
        CMD_RX_MODE = 2'd2,
        CMD_TX_MODE = 2'd3
    } cmd_t;

    // Control into the shared shift unit.
    typedef struct packed {
        logic                    load;
        logic                    step;
        logic [RSPS_SHIFT_W-1:0] value;
        logic [RSPS_CNT_W-1:0]   nbits;
    } sh_ctrl_t;

    // Status out of the shared shift unit.
    typedef struct packed {
        logic msb;
        logic last_bit;
        logic busy;
    } sh_stat_t;

endpackage

// ===== sv/radio_serial_packet_shifter_unit.sv =====
// ----------------------------------------------------------------------------
// radio_serial_packet_shifter_unit
// Three-wire radio interface: serializes address and payload bits, shifts in
// received bits, and shifts out the channel byte for mode changes.
// ----------------------------------------------------------------------------
// Sequencing: a send request is loaded into the shared shift register when accepted,
// then shifts out its serial bits (8 or 16 payload bits, plus 8 per address byte on a first
// element); a mode request shifts out the channel byte, and a receive request completes at once.
// The shared shift register sends one bit a cycle while the output register is free; a stall holds it.
// Reset (aresetn low, synchronous) clears the sequencer, the output valid,
// the receive state and the configuration (channel byte back to 0x64).
// ----------------------------------------------------------------------------
module radio_serial_packet_shifter_unit
    import rsps_pkg::*;
#(
    parameter int MAX_ADDR_BYTES = RSPS_MAX_ADDR_BYTES
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    // Request channel.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // tdata: payload[15:0], wide[16], first[17], rx_bit[18], data_ready[19], zero fill
    input  logic [23:0]               s_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]                s_tuser,
    // tlast: last_element
    input  logic                      s_tlast,

    // Result channel.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // tdata: tx_bit[0], chip_enable[1], chip_select[2], rx_word[18:3], zero fill
    output logic [23:0]               m_tdata,
    // tuser: kind
    output logic                      m_tuser,
    // tlast: last
    output logic                      m_tlast,

    // Configuration write channel.
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [RSPS_CFG_IDX_W-1:0] cfg_index,
    input  logic [RSPS_DEST_W-1:0]    cfg_data
);

    // Width of the address byte index; at least one bit.
    localparam int IDX_W = (MAX_ADDR_BYTES > 1) ? $clog2(MAX_ADDR_BYTES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_DATA
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always accepted.
    // ------------------------------------------------------------------
    logic [RSPS_ADDR_LEN_W-1:0] addr_len_reg;
    logic [RSPS_DEST_W-1:0]     dest_addr_reg;
    logic [RSPS_CHAN_W-1:0]     chan_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_len_reg  <= '0;
            dest_addr_reg <= '0;
            chan_reg      <= RSPS_CHAN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ADDR_LEN:  addr_len_reg  <= cfg_data[RSPS_ADDR_LEN_W-1:0];
                CFG_DEST_ADDR: dest_addr_reg <= cfg_data;
                CFG_CHANNEL:   chan_reg      <= cfg_data[RSPS_CHAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The address length saturates at the number of address bytes supported.
    logic [RSPS_ADDR_LEN_W-1:0] addr_eff;
    assign addr_eff = (addr_len_reg > RSPS_ADDR_LEN_W'(MAX_ADDR_BYTES))
                    ? RSPS_ADDR_LEN_W'(MAX_ADDR_BYTES) : addr_len_reg;

    // Address viewed as bytes, byte 0 in the low bits and sent first.
    logic [MAX_ADDR_BYTES-1:0][7:0] dest_bytes;
    assign dest_bytes = dest_addr_reg[MAX_ADDR_BYTES*8-1:0];

    // Request fields.
    cmd_t                    in_cmd;
    logic [RSPS_SHIFT_W-1:0] in_payload;
    logic                    in_wide;
    logic                    in_first;
    logic                    in_rx_bit;
    logic                    in_data_ready;

    assign in_cmd        = cmd_t'(s_tuser);
    assign in_payload    = s_tdata[15:0];
    assign in_wide       = s_tdata[16];
    assign in_first      = s_tdata[17];
    assign in_rx_bit     = s_tdata[18];
    assign in_data_ready = s_tdata[19];

    // ------------------------------------------------------------------
    // Shared shift unit.
    // ------------------------------------------------------------------
    sh_ctrl_t sh_ctrl;
    sh_stat_t sh_stat;

    rsps_shift_unit u_shift (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (sh_ctrl),
        .stat    (sh_stat)
    );

    // ------------------------------------------------------------------
    // Sequencer, receive state and output register.
    // ------------------------------------------------------------------
    state_t                     state_reg,     state_next;
    logic [RSPS_SHIFT_W-1:0]    payload_reg,   payload_next;
    logic                       wide_reg,      wide_next;
    logic                       last_flag_reg, last_flag_next;
    logic                       ce_reg,        ce_next;
    logic                       cs_reg,        cs_next;
    logic [IDX_W-1:0]           idx_reg,       idx_next;
    logic [RSPS_ADDR_LEN_W-1:0] addr_left_reg, addr_left_next;
    logic [RSPS_SHIFT_W-1:0]    rx_shift_reg,  rx_shift_next;
    logic [RSPS_CNT_W-1:0]      rx_count_reg,  rx_count_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_kind_reg,  out_kind_next;
    logic                       out_tx_reg,    out_tx_next;
    logic                       out_ce_reg,    out_ce_next;
    logic                       out_cs_reg,    out_cs_next;
    logic [RSPS_SHIFT_W-1:0]    out_word_reg,  out_word_next;
    logic                       out_last_reg,  out_last_next;

    logic                       out_free;
    logic                       accept;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        logic [RSPS_SHIFT_W-1:0] rx_shifted;
        logic [RSPS_CNT_W-1:0]   rx_inc;
        logic [RSPS_CNT_W-1:0]   rx_width;
        logic [RSPS_CHAN_W-1:0]  mode_byte;

        state_next     = state_reg;
        payload_next   = payload_reg;
        wide_next      = wide_reg;
        last_flag_next = last_flag_reg;
        ce_next        = ce_reg;
        cs_next        = cs_reg;
        idx_next       = idx_reg;
        addr_left_next = addr_left_reg;
        rx_shift_next  = rx_shift_reg;
        rx_count_next  = rx_count_reg;

        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_tx_next    = out_tx_reg;
        out_ce_next    = out_ce_reg;
        out_cs_next    = out_cs_reg;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;

        sh_ctrl        = '0;

        rx_shifted = {rx_shift_reg[RSPS_SHIFT_W-2:0], in_rx_bit};
        rx_inc     = rx_count_reg + RSPS_CNT_W'(1);
        rx_width   = in_wide ? RSPS_CNT_W'(16) : RSPS_CNT_W'(8);
        mode_byte  = (in_cmd == CMD_RX_MODE) ? (chan_reg | 8'h01) : (chan_reg & 8'hFE);

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_cmd) inside
                        CMD_SEND: begin
                            payload_next   = in_payload;
                            wide_next      = in_wide;
                            last_flag_next = s_tlast;
                            ce_next        = 1'b1;
                            cs_next        = 1'b0;
                            sh_ctrl.load   = 1'b1;
                            if (in_first && (addr_eff != '0)) begin
                                // Address prefix: byte 0 first.
                                sh_ctrl.value  = {dest_bytes[0], 8'h00};
                                sh_ctrl.nbits  = RSPS_CNT_W'(8);
                                idx_next       = IDX_W'(1);
                                addr_left_next = addr_eff - RSPS_ADDR_LEN_W'(1);
                                state_next     = ST_ADDR;
                            end else begin
                                sh_ctrl.value = in_wide ? in_payload
                                                        : {in_payload[7:0], 8'h00};
                                sh_ctrl.nbits = in_wide ? RSPS_CNT_W'(16)
                                                        : RSPS_CNT_W'(8);
                                state_next    = ST_DATA;
                            end
                        end
                        CMD_RECEIVE: begin
                            if (!in_data_ready) begin
                                // Data-ready dropped: discard the partial element.
                                rx_shift_next = '0;
                                rx_count_next = '0;
                            end else if (rx_inc >= rx_width) begin
                                out_valid_next = 1'b1;
                                out_kind_next  = 1'b1;
                                out_tx_next    = 1'b0;
                                out_ce_next    = 1'b0;
                                out_cs_next    = 1'b0;
                                out_word_next  = in_wide ? rx_shifted
                                                         : {8'h00, rx_shifted[7:0]};
                                out_last_next  = 1'b1;
                                rx_shift_next  = '0;
                                rx_count_next  = '0;
                            end else begin
                                rx_shift_next = rx_shifted;
                                rx_count_next = rx_inc;
                            end
                        end
                        CMD_RX_MODE, CMD_TX_MODE: begin
                            last_flag_next = 1'b1;
                            ce_next        = 1'b0;
                            cs_next        = 1'b1;
                            sh_ctrl.load   = 1'b1;
                            sh_ctrl.value  = {mode_byte, 8'h00};
                            sh_ctrl.nbits  = RSPS_CNT_W'(8);
                            state_next     = ST_DATA;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADDR: begin
                if (out_free) begin
                    sh_ctrl.step   = 1'b1;
                    out_valid_next = 1'b1;
                    out_kind_next  = 1'b0;
                    out_tx_next    = sh_stat.msb;
                    out_ce_next    = ce_reg;
                    out_cs_next    = cs_reg;
                    out_word_next  = '0;
                    out_last_next  = 1'b0;
                    if (sh_stat.last_bit) begin
                        sh_ctrl.load = 1'b1;
                        if (addr_left_reg != '0) begin
                            sh_ctrl.value  = {dest_bytes[idx_reg], 8'h00};
                            sh_ctrl.nbits  = RSPS_CNT_W'(8);
                            idx_next       = idx_reg + IDX_W'(1);
                            addr_left_next = addr_left_reg - RSPS_ADDR_LEN_W'(1);
                        end else begin
                            sh_ctrl.value = wide_reg ? payload_reg
                                                     : {payload_reg[7:0], 8'h00};
                            sh_ctrl.nbits = wide_reg ? RSPS_CNT_W'(16)
                                                     : RSPS_CNT_W'(8);
                            state_next    = ST_DATA;
                        end
                    end
                end
            end
            ST_DATA: begin
                if (out_free) begin
                    sh_ctrl.step   = 1'b1;
                    out_valid_next = 1'b1;
                    out_kind_next  = 1'b0;
                    out_tx_next    = sh_stat.msb;
                    out_ce_next    = ce_reg;
                    out_cs_next    = cs_reg;
                    out_word_next  = '0;
                    out_last_next  = last_flag_reg && sh_stat.last_bit;
                    if (sh_stat.last_bit) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rx_shift_reg  <= '0;
            rx_count_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rx_shift_reg  <= rx_shift_next;
            rx_count_reg  <= rx_count_next;
        end
        payload_reg   <= payload_next;
        wide_reg      <= wide_next;
        last_flag_reg <= last_flag_next;
        ce_reg        <= ce_next;
        cs_reg        <= cs_next;
        idx_reg       <= idx_next;
        addr_left_reg <= addr_left_next;
        out_kind_reg  <= out_kind_next;
        out_tx_reg    <= out_tx_next;
        out_ce_reg    <= out_ce_next;
        out_cs_reg    <= out_cs_next;
        out_word_reg  <= out_word_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b00000, out_word_reg, out_cs_reg, out_ce_reg, out_tx_reg};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // While the sequencer is shifting, the shift unit still holds bits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> sh_stat.busy)
        else $error("sequencer active with an empty shift unit");

    // A received element never drives the serial line controls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[2:0] == 3'b000)))
        else $error("received element carries serial controls");

    // A serial bit drives exactly one of chip enable and chip select.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> ((m_tdata[1] != m_tdata[2]) && (m_tdata[18:3] == '0)))
        else $error("serial bit with bad chip controls or nonzero word");

endmodule

// ===== sv/rsps_shift_unit.sv =====
// ----------------------------------------------------------------------------
// rsps_shift_unit
// Shared MSB-first shift register with a bit counter, reloaded per byte or word.
// ----------------------------------------------------------------------------
module rsps_shift_unit
    import rsps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  sh_ctrl_t ctrl,
    output sh_stat_t stat
);

    logic [RSPS_SHIFT_W-1:0] sh_reg;
    logic [RSPS_SHIFT_W-1:0] sh_next;
    logic [RSPS_CNT_W-1:0]   cnt_reg;
    logic [RSPS_CNT_W-1:0]   cnt_next;

    // A load wins over a step: the bit shown this cycle is still taken out.
    always_comb begin
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (ctrl.load) begin
            sh_next  = ctrl.value;
            cnt_next = ctrl.nbits;
        end else if (ctrl.step) begin
            sh_next  = {sh_reg[RSPS_SHIFT_W-2:0], 1'b0};
            cnt_next = cnt_reg - RSPS_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        sh_reg <= sh_next;
    end

    assign stat.msb      = sh_reg[RSPS_SHIFT_W-1];
    assign stat.last_bit = (cnt_reg == RSPS_CNT_W'(1));
    assign stat.busy     = (cnt_reg != '0);

endmodule
